// File: design/swsj_pkg.sv
`default_nettype none
package swsj_pkg;

  localparam int KEY_W   = 32;
  localparam int STAMP_W = 31;
  localparam int WIN_W   = 16;
  localparam int WORK_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_TUPLE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;
  localparam logic SIDE_R    = 1'b0;
  localparam logic SIDE_S    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORKERS = 1'd1;

  typedef struct packed {
    logic               cmd;
    logic               stream_side;
    logic [KEY_W-1:0]   join_key;
    logic [STAMP_W-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [WIN_W-1:0]   window_tag;
    logic [KEY_W-1:0]   match_key;
    logic [STAMP_W-1:0] s_stamp;
    logic [STAMP_W-1:0] r_stamp;
    logic               last;
    logic               overflow;
  } out_item_t;

endpackage
`default_nettype wire

// File: design/swsj_front.sv
`default_nettype none
module swsj_front #(
  parameter int CW = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire swsj_pkg::in_item_t     in_data,
  input  wire logic [CW:0]            ncores,
  output logic                        q_valid,
  input  wire logic                   q_ready,
  output logic [$bits(swsj_pkg::in_item_t)+2*CW:0] q_data
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t             state;
  swsj_pkg::in_item_t  item;
  logic [CW:0]         div;
  logic [CW-1:0]       rem;
  logic [4:0]          cnt;
  logic [CW:0]         trial;

  assign in_ready = (state == F_IDLE);
  assign q_valid  = (state == F_PUSH);
  assign q_data   = {item, rem, div};
  assign trial    = {rem, item.stamp[cnt]};

  // restoring remainder, one stamp bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            div  <= ncores;
            rem  <= '0;
            cnt  <= 5'(swsj_pkg::STAMP_W - 1);
            if (in_data.cmd == swsj_pkg::CMD_CLEAR || ncores == (CW+1)'(1)) begin
              state <= F_PUSH;
            end else begin
              state <= F_DIV;
            end
          end
        end
        F_DIV: begin
          if (trial >= div) begin
            rem <= CW'(trial - div);
          end else begin
            rem <= CW'(trial);
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/swsj_queue.sv
`default_nettype none
module swsj_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_ready,
  output logic [W-1:0]      rd_data
);

  logic [W-1:0] slots [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;
  logic         push;
  logic         pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slots[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/swsj_back.sv
`default_nettype none
module swsj_back #(
  parameter int STORE_DEPTH = 64,
  parameter int CW = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  output logic                        q_ready,
  input  wire logic [$bits(swsj_pkg::in_item_t)+2*CW:0] q_data,
  input  wire logic [swsj_pkg::WIN_W-1:0] window_number,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output swsj_pkg::out_item_t         out_data
);

  localparam int IW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNTW = $clog2(STORE_DEPTH + 1);
  localparam int EW   = swsj_pkg::KEY_W + swsj_pkg::STAMP_W + CW;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_CHECK, B_FLUSH} bstate_t;

  bstate_t             state;
  swsj_pkg::in_item_t  q_item;
  logic [CW-1:0]       q_core;
  logic [CW:0]         q_ncores;

  logic [EW-1:0]       r_mem [STORE_DEPTH];
  logic [EW-1:0]       s_mem [STORE_DEPTH];
  logic [EW-1:0]       r_rd;
  logic [EW-1:0]       s_rd;
  logic [IW-1:0]       rd_addr;
  logic                we_r;
  logic                we_s;
  logic [IW-1:0]       wr_addr;
  logic [EW-1:0]       wr_entry;

  logic [CNTW-1:0]     r_count;
  logic [CNTW-1:0]     s_count;
  logic [CNTW-1:0]     own_count;
  logic                overflow_seen;

  swsj_pkg::in_item_t  cur;
  logic [CW:0]         ncores;
  logic [CW:0]         c;
  logic [CNTW-1:0]     i;
  logic [CNTW-1:0]     scan_len;

  logic [EW-1:0]       other;
  logic [swsj_pkg::KEY_W-1:0]   o_key;
  logic [swsj_pkg::STAMP_W-1:0] o_stamp;
  logic [CW-1:0]       o_core;
  logic                hit;
  logic                slot_free;
  logic                stall;
  swsj_pkg::out_item_t hit_item;
  swsj_pkg::out_item_t pend;
  logic                pend_valid;
  logic                out_load;
  swsj_pkg::out_item_t out_next;

  assign {q_item, q_core, q_ncores} = q_data;
  assign q_ready   = (state == B_IDLE);
  assign own_count = (q_item.stream_side == swsj_pkg::SIDE_S) ? s_count : r_count;
  assign wr_addr   = own_count[IW-1:0];
  assign wr_entry  = {q_item.join_key, q_item.stamp, q_core};
  assign we_r = (state == B_IDLE) && q_valid && (q_item.cmd == swsj_pkg::CMD_TUPLE)
                && (q_item.stream_side == swsj_pkg::SIDE_R)
                && (own_count < CNTW'(STORE_DEPTH));
  assign we_s = (state == B_IDLE) && q_valid && (q_item.cmd == swsj_pkg::CMD_TUPLE)
                && (q_item.stream_side == swsj_pkg::SIDE_S)
                && (own_count < CNTW'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (we_r) r_mem[wr_addr] <= wr_entry;
    if (we_s) s_mem[wr_addr] <= wr_entry;
    r_rd <= r_mem[rd_addr];
    s_rd <= s_mem[rd_addr];
  end

  assign other = (cur.stream_side == swsj_pkg::SIDE_S) ? r_rd : s_rd;
  assign {o_key, o_stamp, o_core} = other;
  assign hit       = (o_core == c[CW-1:0]) && (o_key == cur.join_key);
  assign slot_free = !out_valid || out_ready;
  assign stall     = hit && pend_valid && !slot_free;

  always_comb begin
    hit_item.window_tag = window_number;
    hit_item.match_key  = cur.join_key;
    hit_item.s_stamp    = (cur.stream_side == swsj_pkg::SIDE_S) ? cur.stamp : o_stamp;
    hit_item.r_stamp    = (cur.stream_side == swsj_pkg::SIDE_S) ? o_stamp : cur.stamp;
    hit_item.last       = 1'b0;
    hit_item.overflow   = overflow_seen;
  end

  // held match goes out when a newer one replaces it, or with last at the end
  always_comb begin
    out_load = 1'b0;
    out_next = pend;
    if (state == B_CHECK && !stall && hit && pend_valid) begin
      out_load = 1'b1;
    end
    if (state == B_FLUSH && pend_valid && slot_free) begin
      out_load      = 1'b1;
      out_next.last = 1'b1;
    end
  end

  // one match is held back so the final one of a scan can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      r_count       <= '0;
      s_count       <= '0;
      overflow_seen <= 1'b0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_data  <= out_next;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            if (q_item.cmd == swsj_pkg::CMD_CLEAR) begin
              r_count <= '0;
              s_count <= '0;
            end else begin
              cur     <= q_item;
              ncores  <= q_ncores;
              c       <= '0;
              i       <= '0;
              rd_addr <= '0;
              if (own_count < CNTW'(STORE_DEPTH)) begin
                if (q_item.stream_side == swsj_pkg::SIDE_S) begin
                  s_count <= s_count + CNTW'(1);
                end else begin
                  r_count <= r_count + CNTW'(1);
                end
              end else begin
                overflow_seen <= 1'b1;
              end
              scan_len <= (q_item.stream_side == swsj_pkg::SIDE_S) ? r_count : s_count;
              if (((q_item.stream_side == swsj_pkg::SIDE_S) ? r_count : s_count)
                  == '0) begin
                state <= B_FLUSH;
              end else begin
                state <= B_READ;
              end
            end
          end
        end
        B_READ: begin
          state <= B_CHECK;
        end
        B_CHECK: begin
          if (!stall) begin
            if (hit) begin
              pend       <= hit_item;
              pend_valid <= 1'b1;
            end
            if (i + CNTW'(1) < scan_len) begin
              i       <= i + CNTW'(1);
              rd_addr <= IW'(i + CNTW'(1));
              state   <= B_READ;
            end else if (c + (CW+1)'(1) < ncores) begin
              c       <= c + (CW+1)'(1);
              i       <= '0;
              rd_addr <= '0;
              state   <= B_READ;
            end else begin
              state <= B_FLUSH;
            end
          end
        end
        B_FLUSH: begin
          if (!pend_valid) begin
            state <= B_IDLE;
          end else if (slot_free) begin
            pend_valid <= 1'b0;
            state      <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/split_window_stream_join.sv
// Channel  Signals                        Transfer when
// in       in_valid/in_ready/in_data      in_valid & in_ready
// out      out_valid/out_ready/out_data   out_valid & out_ready
// cfg      cfg_we/cfg_index/cfg_data      cfg_we
//
// Front: a clear or a single core needs no division, else remainder steps
// (one stamp bit per cycle) over the stamp find the storing core.
// Back: for each core, every entry of the other side's store is read and
// compared (registered store read, then compare).
// Reset is synchronous; fill counts and overflow clear, store contents do not.
// A stalled output holds back the scan only when a second match is found.
`default_nettype none
module split_window_stream_join #(
  parameter int STORE_DEPTH = 64,
  parameter int MAX_CORES   = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire swsj_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output swsj_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [swsj_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [swsj_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int QW = $bits(swsj_pkg::in_item_t) + 2 * CW + 1;

  logic [swsj_pkg::WIN_W-1:0]  window_number;
  logic [swsj_pkg::WORK_W-1:0] worker_count;
  logic [CW:0]                 ncores;

  logic          fq_valid;
  logic          fq_ready;
  logic [QW-1:0] fq_data;
  logic          qb_valid;
  logic          qb_ready;
  logic [QW-1:0] qb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_number <= '0;
      worker_count  <= swsj_pkg::WORK_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        swsj_pkg::REG_WINDOW:  window_number <= cfg_data[swsj_pkg::WIN_W-1:0];
        swsj_pkg::REG_WORKERS: worker_count  <= cfg_data[swsj_pkg::WORK_W-1:0];
        default: ;
      endcase
    end
  end

  // zero workers means one core; above the core count saturates
  always_comb begin
    if (worker_count == '0) begin
      ncores = (CW+1)'(1);
    end else if (32'(worker_count) > 32'(MAX_CORES)) begin
      ncores = (CW+1)'(MAX_CORES);
    end else begin
      ncores = (CW+1)'(worker_count);
    end
  end

  swsj_front #(.CW(CW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ncores   (ncores),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  swsj_queue #(.W(QW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  swsj_back #(.STORE_DEPTH(STORE_DEPTH), .CW(CW)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (qb_valid),
    .q_ready       (qb_ready),
    .q_data        (qb_data),
    .window_number (window_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire
